FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the template walker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: check failed");

// When the trigger holds, the consequence must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/iptlw_pkg.sv
// ---------------------------------------------------------------------------
// IPFIX template length walker package
// Item types, the walker phase type and the protocol constants.
// ---------------------------------------------------------------------------
package iptlw_pkg;

	localparam int QueueDepth = 2;

	localparam logic [15:0] VarLen    = 16'hFFFF;
	localparam int          EntBit    = 15;
	localparam logic [16:0] SpecBytes = 17'd4;
	localparam logic [16:0] EntBytes  = 17'd4;

	typedef struct packed {
		logic [15:0] word;
		logic        first;
		logic        options;
		logic [15:0] avail_bytes;
	} in_item_t;

	typedef struct packed {
		logic [15:0] tmpl_id;
		logic [15:0] num_specs;
		logic [15:0] spec_bytes;
		logic [30:0] data_min_len;
		logic        variable_len;
		logic        status;
	} out_item_t;

	// Input item after classification in the front part.
	typedef struct packed {
		logic [15:0] word;
		logic        first;
		logic        options;
		logic [15:0] avail_bytes;
		logic        ent;
		logic        var_len;
	} cls_item_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COUNT,
		PH_SCOPE,
		PH_EID,
		PH_LEN,
		PH_ENT1,
		PH_ENT2
	} phase_t;

endpackage

FILE: rtl/core/iptlw_front.sv
// ---------------------------------------------------------------------------
// Template walker front part
// Accepts input items, classifies each word and holds them in a short queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iptlw_front #(
	parameter int Depth = iptlw_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  iptlw_pkg::in_item_t item,
	output logic                q_valid,
	input  logic                q_pop,
	output iptlw_pkg::cls_item_t q_item
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	iptlw_pkg::cls_item_t mem_q [Depth];
	iptlw_pkg::cls_item_t cls;
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push, pop, full;

	assign full       = (count_q == CntW'(Depth));
	assign item_stall = full;
	assign push       = item_valid && !full;
	assign pop        = q_pop && q_valid;
	assign q_valid    = (count_q != '0);
	assign q_item     = mem_q[rd_ptr_q];

	always_comb begin
		cls.word        = item.word;
		cls.first       = item.first;
		cls.options     = item.options;
		cls.avail_bytes = item.avail_bytes;
		cls.ent         = item.word[iptlw_pkg::EntBit];
		cls.var_len     = (item.word == iptlw_pkg::VarLen);
	end

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CntW'(Depth))
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

FILE: rtl/core/iptlw_back.sv
// ---------------------------------------------------------------------------
// Template walker back part; a record's last word waits on a held result.
// Walks the record one classified word per cycle and registers the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iptlw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  iptlw_pkg::cls_item_t q_item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output iptlw_pkg::out_item_t result
);

	iptlw_pkg::phase_t phase_q, phase_d;
	logic [15:0] fields_left_q, fields_left_d;
	logic [16:0] spec_total_q, spec_total_d;
	logic [30:0] data_total_q, data_total_d;
	logic        var_seen_q, var_seen_d;
	logic        ent_pending_q, ent_pending_d;
	logic [15:0] record_id_q, record_id_d;
	logic [15:0] record_count_q, record_count_d;
	logic [15:0] byte_limit_q, byte_limit_d;
	logic        is_options_q, is_options_d;

	logic        take, emit, bad;
	logic        res_valid_q;
	iptlw_pkg::out_item_t res_q;
	logic [16:0] spec_sum;
	logic [30:0] data_sum;
	logic [15:0] fields_dec;
	logic        bad_zeroed;

	// A word that ends a record waits while the result register is held;
	// every other word goes on regardless of the receiver.
	assign take  = q_valid && (!emit || !res_valid_q || !result_stall);
	assign q_pop = take;

	assign spec_sum   = spec_total_q + iptlw_pkg::SpecBytes
		+ (ent_pending_q ? iptlw_pkg::EntBytes : 17'd0);
	assign data_sum   = data_total_q + (q_item.var_len ? 31'd1 : {15'd0, q_item.word});
	assign fields_dec = fields_left_q - 1'b1;

	always_comb begin
		phase_d        = phase_q;
		fields_left_d  = fields_left_q;
		spec_total_d   = spec_total_q;
		data_total_d   = data_total_q;
		var_seen_d     = var_seen_q;
		ent_pending_d  = ent_pending_q;
		record_id_d    = record_id_q;
		record_count_d = record_count_q;
		byte_limit_d   = byte_limit_q;
		is_options_d   = is_options_q;
		emit           = 1'b0;
		bad            = 1'b0;
		if (q_item.first) begin
			record_id_d    = q_item.word;
			is_options_d   = q_item.options;
			byte_limit_d   = q_item.avail_bytes;
			record_count_d = '0;
			fields_left_d  = '0;
			spec_total_d   = '0;
			data_total_d   = '0;
			var_seen_d     = 1'b0;
			ent_pending_d  = 1'b0;
			phase_d        = iptlw_pkg::PH_COUNT;
		end else begin
			case (phase_q)
				iptlw_pkg::PH_COUNT: begin
					record_count_d = q_item.word;
					fields_left_d  = q_item.word;
					if (is_options_q) begin
						phase_d = iptlw_pkg::PH_SCOPE;
					end else if (q_item.word == '0) begin
						emit = 1'b1;
					end else begin
						phase_d = iptlw_pkg::PH_EID;
					end
				end
				iptlw_pkg::PH_SCOPE: begin
					if (fields_left_q == '0) begin
						emit = 1'b1;
					end else begin
						phase_d = iptlw_pkg::PH_EID;
					end
				end
				iptlw_pkg::PH_EID: begin
					ent_pending_d = q_item.ent;
					phase_d       = iptlw_pkg::PH_LEN;
				end
				iptlw_pkg::PH_LEN: begin
					data_total_d = data_sum;
					spec_total_d = spec_sum;
					if (q_item.var_len) begin
						var_seen_d = 1'b1;
					end
					if (spec_sum > {1'b0, byte_limit_q}) begin
						emit = 1'b1;
						bad  = 1'b1;
					end else if (ent_pending_q) begin
						phase_d = iptlw_pkg::PH_ENT1;
					end else begin
						fields_left_d = fields_dec;
						if (fields_dec == '0) begin
							emit = 1'b1;
						end else begin
							phase_d = iptlw_pkg::PH_EID;
						end
					end
				end
				iptlw_pkg::PH_ENT1: begin
					phase_d = iptlw_pkg::PH_ENT2;
				end
				iptlw_pkg::PH_ENT2: begin
					fields_left_d = fields_dec;
					if (fields_dec == '0) begin
						emit = 1'b1;
					end else begin
						phase_d = iptlw_pkg::PH_EID;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
			if (emit) begin
				phase_d = iptlw_pkg::PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= iptlw_pkg::PH_IDLE;
			fields_left_q  <= '0;
			spec_total_q   <= '0;
			data_total_q   <= '0;
			var_seen_q     <= 1'b0;
			ent_pending_q  <= 1'b0;
			record_id_q    <= '0;
			record_count_q <= '0;
			byte_limit_q   <= '0;
			is_options_q   <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				phase_q        <= phase_d;
				fields_left_q  <= fields_left_d;
				spec_total_q   <= spec_total_d;
				data_total_q   <= data_total_d;
				var_seen_q     <= var_seen_d;
				ent_pending_q  <= ent_pending_d;
				record_id_q    <= record_id_d;
				record_count_q <= record_count_d;
				byte_limit_q   <= byte_limit_d;
				is_options_q   <= is_options_d;
			end
			if (take && emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// A malformed record reports only its header fields and a set status bit.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q.tmpl_id      <= record_id_q;
			res_q.num_specs    <= record_count_d;
			res_q.spec_bytes   <= bad ? 16'd0 : spec_total_d[15:0];
			res_q.data_min_len <= bad ? 31'd0 : data_total_d;
			res_q.variable_len <= bad ? 1'b0 : var_seen_d;
			res_q.status       <= bad;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign bad_zeroed = (res_q.spec_bytes == '0) && (res_q.data_min_len == '0)
		&& !res_q.variable_len;

	`ASSERT_NEXT(a_idle_after_result, clk, arst_n, take && emit, phase_q == iptlw_pkg::PH_IDLE)
	`ASSERT_ALWAYS(a_bad_is_empty, clk, arst_n, !(res_valid_q && res_q.status) || bad_zeroed)

endmodule

FILE: rtl/core/ipfix_template_length_walker_unit.sv
// ---------------------------------------------------------------------------
// IPFIX template length walker
// Walks template and options-template records word by word and reports
// the header, specifier byte total, minimum data length and status.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (item_valid, item_stall, item) carries one 16-bit record
// word per item; first marks the template ID word and brings the options flag
// and the available byte count with it. The result channel (result_valid,
// result_stall, result) carries one item per finished or malformed record.
// Throughput is one word per cycle unless a held result stalls a record end;
// the front queue of Depth entries decouples input from the walker.
// result_valid rises once the word ending the record has passed the front
// queue and the walker has written the result register.
// While the receiver stalls, the result register holds its item; the walker
// keeps consuming words up to the next record's last word, which waits, and
// the front queue then fills and raises item_stall.
// Reset empties the queue, drops any record in progress and leaves the walker
// idle, ignoring words until the next first word.
// ---------------------------------------------------------------------------
module ipfix_template_length_walker_unit #(
	parameter int Depth = iptlw_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  iptlw_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output iptlw_pkg::out_item_t result
);

	logic                 q_valid, q_pop;
	iptlw_pkg::cls_item_t q_item;

	iptlw_front #(
		.Depth(Depth)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	iptlw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
